// ===== sv/aws_pkg.sv =====
// aws_pkg: shared types and constants for the anagram window search block
// depends on nothing; used by aws_need_table and anagram_window_search
package aws_pkg;

    // sizes of the word store and the text position range
    localparam int WORD_MAX   = 32;
    localparam int TEXT_DEPTH = 1024;

    // derived widths
    localparam int CH_W      = 8;
    localparam int CH_COUNT  = 1 << CH_W;
    localparam int POS_W     = $clog2(TEXT_DEPTH);
    localparam int TPOS_W    = $clog2(TEXT_DEPTH + 1);
    localparam int LEN_W     = $clog2(WORD_MAX + 1);
    localparam int WIN_IDX_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
    localparam int NEED_W    = $clog2(WORD_MAX + 1) + 1;
    localparam int NZ_W      = CH_W + 1;

    // special characters
    localparam logic [CH_W-1:0] END_MARK = 8'h7E;
    localparam logic [CH_W-1:0] SPACE_CH = 8'h20;

    // command codes
    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_WORD  = 2'd1,
        CMD_TEXT  = 2'd2
    } cmd_t;

    // input item
    typedef struct packed {
        cmd_t            cmd;
        logic [CH_W-1:0] ch;
    } in_item_t;

    // result item
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] span_start;
        logic [POS_W-1:0] span_end;
    } out_item_t;

    // update request for the need table
    typedef struct packed {
        logic            clear;
        logic            word_add;
        logic            text_sub;
        logic            text_ret;
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] old_ch;
    } need_upd_t;

endpackage

// ===== sv/aws_need_table.sv =====
// aws_need_table: per-character signed need table and count of nonzero entries
// depends on aws_pkg; the table is a memory read in the cycle before its use
module aws_need_table (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  aws_pkg::need_upd_t       upd,
    input  logic [aws_pkg::CH_W-1:0] rd_ch,
    input  logic [aws_pkg::CH_W-1:0] rd_old_ch,
    output logic [aws_pkg::NZ_W-1:0] nz_next
);

    // table memory, with one flag per entry marking it written since the last clear
    logic signed [aws_pkg::NEED_W-1:0] need_mem [aws_pkg::CH_COUNT];
    logic [aws_pkg::CH_COUNT-1:0]      live_reg, live_next;
    logic [aws_pkg::NZ_W-1:0]          nz_reg;

    // registered read data and forwarding of same-edge writes
    logic signed [aws_pkg::NEED_W-1:0] a_mem_reg, b_mem_reg;
    logic signed [aws_pkg::NEED_W-1:0] a_fwd_reg, a_fwd_next;
    logic signed [aws_pkg::NEED_W-1:0] b_fwd_reg, b_fwd_next;
    logic                              a_live_reg, b_live_reg;
    logic                              a_hit_reg, a_hit_next;
    logic                              b_hit_reg, b_hit_next;

    logic signed [aws_pkg::NEED_W-1:0] a_val;
    logic signed [aws_pkg::NEED_W-1:0] a_after;
    logic signed [aws_pkg::NEED_W-1:0] b_mem_val;
    logic signed [aws_pkg::NEED_W-1:0] b_val;
    logic signed [aws_pkg::NEED_W-1:0] b_after;
    logic                              chg_a, wr_a, wr_b;
    logic                              inc1, dec1, inc2, dec2;

    // current entry values and the new values
    always_comb begin
        chg_a     = upd.word_add || upd.text_sub;
        wr_b      = upd.text_ret;
        // returning the same character leaves only the second write
        wr_a      = chg_a && !(wr_b && (upd.old_ch == upd.ch));
        a_val     = a_hit_reg ? a_fwd_reg : (a_live_reg ? a_mem_reg : '0);
        a_after   = upd.text_sub ? a_val - aws_pkg::NEED_W'(1)
                                 : a_val + aws_pkg::NEED_W'(1);
        b_mem_val = b_hit_reg ? b_fwd_reg : (b_live_reg ? b_mem_reg : '0);
        // returning the same character sees the entry after the first change
        b_val     = (upd.old_ch == upd.ch) ? a_after : b_mem_val;
        b_after   = b_val + aws_pkg::NEED_W'(1);
    end

    // nonzero bookkeeping for the one or two changes
    always_comb begin
        inc1 = chg_a && (a_val == '0);
        dec1 = chg_a && (a_after == '0);
        inc2 = upd.text_ret && (b_val == '0);
        dec2 = upd.text_ret && (b_after == '0);
        if (upd.clear) begin
            nz_next = '0;
        end else begin
            nz_next = nz_reg + aws_pkg::NZ_W'(inc1) + aws_pkg::NZ_W'(inc2)
                      - aws_pkg::NZ_W'(dec1) - aws_pkg::NZ_W'(dec2);
        end
    end

    // forwarding for reads that meet a write at the same edge, second write first
    always_comb begin
        if (wr_b && (upd.old_ch == rd_ch)) begin
            a_hit_next = 1'b1;
            a_fwd_next = b_after;
        end else if (chg_a && (upd.ch == rd_ch)) begin
            a_hit_next = 1'b1;
            a_fwd_next = a_after;
        end else begin
            a_hit_next = 1'b0;
            a_fwd_next = '0;
        end
        if (wr_b && (upd.old_ch == rd_old_ch)) begin
            b_hit_next = 1'b1;
            b_fwd_next = b_after;
        end else if (chg_a && (upd.ch == rd_old_ch)) begin
            b_hit_next = 1'b1;
            b_fwd_next = a_after;
        end else begin
            b_hit_next = 1'b0;
            b_fwd_next = '0;
        end
        live_next = live_reg;
        if (chg_a) begin
            live_next[upd.ch] = 1'b1;
        end
        if (wr_b) begin
            live_next[upd.old_ch] = 1'b1;
        end
    end

    // table memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            need_mem[upd.ch] <= a_after;
        end
        if (wr_b) begin
            need_mem[upd.old_ch] <= b_after;
        end
        a_mem_reg <= need_mem[rd_ch];
        b_mem_reg <= need_mem[rd_old_ch];
    end

    // written flags, count and forwarding registers
    always_ff @(posedge aclk) begin
        if (!aresetn || upd.clear) begin
            live_reg   <= '0;
            nz_reg     <= '0;
            a_live_reg <= 1'b0;
            b_live_reg <= 1'b0;
            a_hit_reg  <= 1'b0;
            b_hit_reg  <= 1'b0;
            a_fwd_reg  <= '0;
            b_fwd_reg  <= '0;
        end else begin
            live_reg   <= live_next;
            nz_reg     <= nz_next;
            a_live_reg <= live_reg[rd_ch];
            b_live_reg <= live_reg[rd_old_ch];
            a_hit_reg  <= a_hit_next;
            b_hit_reg  <= b_hit_next;
            a_fwd_reg  <= a_fwd_next;
            b_fwd_reg  <= b_fwd_next;
        end
    end

endmodule

// ===== sv/anagram_window_search.sv =====
// anagram_window_search: top level of the anagram window search block
// depends on aws_pkg and aws_need_table
//
// Load a word with word-character commands, then stream text characters; each
// text character gives one result transfer that flags whether the last
// word-length non-space characters form an anagram of the word, with the span
// start and end positions. A clear command resets the word, the text position
// and the need table. One item is taken every cycle while results are taken:
// an input register feeds a combinational update of the need table and the
// shift window, which loads the result register, so each result is registered
// behind the input register. The need table is a memory read at two characters
// a cycle, in the cycle before use, with the writes of the item in hand
// forwarded to the next one, so it costs no rate. A text item waits in the
// input register while an earlier result is not taken; s_ready then follows m_ready combinationally.
module anagram_window_search (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  aws_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output aws_pkg::out_item_t m_item
);

    // input register
    logic               in_valid_reg;
    aws_pkg::in_item_t  in_reg;

    // block state
    logic [aws_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [aws_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic [aws_pkg::TPOS_W-1:0] tpos_reg, tpos_next;
    logic                       ended_reg, ended_next;
    logic [aws_pkg::CH_W-1:0]   win_ch_reg   [aws_pkg::WORD_MAX];
    logic [aws_pkg::POS_W-1:0]  win_pos_reg  [aws_pkg::WORD_MAX];
    logic [aws_pkg::CH_W-1:0]   win_ch_next  [aws_pkg::WORD_MAX];
    logic [aws_pkg::POS_W-1:0]  win_pos_next [aws_pkg::WORD_MAX];

    // result register
    logic               m_valid_reg;
    aws_pkg::out_item_t m_item_reg, m_item_next;

    // decode
    logic                         adv;
    logic                         is_clear, is_word, is_text;
    logic                         word_take, text_live, char_take, win_take;
    logic                         full;
    logic [aws_pkg::WIN_IDX_W-1:0] ins_idx;
    logic [aws_pkg::POS_W-1:0]    pos;
    logic [aws_pkg::LEN_W-1:0]    len_minus1;
    aws_pkg::need_upd_t           upd;
    logic [aws_pkg::NZ_W-1:0]     nz_next;
    logic [aws_pkg::CH_W-1:0]     rd_ch, rd_old_ch;

    // handshake: the held item moves on when it is not text or its result slot is free
    assign is_clear = (in_reg.cmd == aws_pkg::CMD_CLEAR);
    assign is_word  = (in_reg.cmd == aws_pkg::CMD_WORD);
    assign is_text  = (in_reg.cmd == aws_pkg::CMD_TEXT);
    assign adv      = in_valid_reg && (!is_text || !m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || adv;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // character classification
    always_comb begin
        word_take = adv && is_word && (tpos_reg == '0) && !ended_reg
                    && (in_reg.ch != aws_pkg::SPACE_CH)
                    && (len_reg < aws_pkg::LEN_W'(aws_pkg::WORD_MAX));
        text_live = adv && is_text && !ended_reg;
        char_take = text_live && (in_reg.ch != aws_pkg::END_MARK);
        win_take  = char_take && (in_reg.ch != aws_pkg::SPACE_CH) && (len_reg != '0);
        full      = (fill_reg >= len_reg);
        len_minus1 = len_reg - 1'b1;
        ins_idx   = full ? len_minus1[aws_pkg::WIN_IDX_W-1:0]
                         : fill_reg[aws_pkg::WIN_IDX_W-1:0];
        if (tpos_reg < aws_pkg::TPOS_W'(aws_pkg::TEXT_DEPTH)) begin
            pos = tpos_reg[aws_pkg::POS_W-1:0];
        end else begin
            pos = aws_pkg::POS_W'(aws_pkg::TEXT_DEPTH - 1);
        end
    end

    // need table request
    always_comb begin
        upd.clear    = adv && is_clear;
        upd.word_add = word_take;
        upd.text_sub = win_take;
        upd.text_ret = win_take && full;
        upd.ch       = in_reg.ch;
        upd.old_ch   = win_ch_reg[0];
    end

    // table read addresses for what the registers hold after this edge
    assign rd_ch     = (s_valid && s_ready) ? s_item.ch : in_reg.ch;
    assign rd_old_ch = win_take ? win_ch_next[0] : win_ch_reg[0];

    aws_need_table u_need (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd       (upd),
        .rd_ch     (rd_ch),
        .rd_old_ch (rd_old_ch),
        .nz_next   (nz_next)
    );

    // window shift and insert
    always_comb begin
        for (int i = 0; i < aws_pkg::WORD_MAX - 1; i++) begin
            win_ch_next[i]  = full ? win_ch_reg[i+1]  : win_ch_reg[i];
            win_pos_next[i] = full ? win_pos_reg[i+1] : win_pos_reg[i];
        end
        win_ch_next[aws_pkg::WORD_MAX-1]  = win_ch_reg[aws_pkg::WORD_MAX-1];
        win_pos_next[aws_pkg::WORD_MAX-1] = win_pos_reg[aws_pkg::WORD_MAX-1];
        win_ch_next[ins_idx]  = in_reg.ch;
        win_pos_next[ins_idx] = pos;
    end

    // scalar state and result
    always_comb begin
        len_next   = len_reg;
        fill_next  = fill_reg;
        tpos_next  = tpos_reg;
        ended_next = ended_reg;
        if (adv && is_clear) begin
            len_next   = '0;
            fill_next  = '0;
            tpos_next  = '0;
            ended_next = 1'b0;
        end else begin
            if (word_take) begin
                len_next = len_reg + 1'b1;
            end
            if (text_live && (in_reg.ch == aws_pkg::END_MARK)) begin
                ended_next = 1'b1;
            end
            if (char_take && (tpos_reg < aws_pkg::TPOS_W'(aws_pkg::TEXT_DEPTH))) begin
                tpos_next = tpos_reg + 1'b1;
            end
            if (win_take) begin
                fill_next = full ? len_reg : fill_reg + 1'b1;
            end
        end
        m_item_next.found      = win_take && (fill_next == len_reg) && (nz_next == '0);
        m_item_next.span_start = m_item_next.found ? win_pos_next[0] : '0;
        m_item_next.span_end   = pos;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            len_reg      <= '0;
            fill_reg     <= '0;
            tpos_reg     <= '0;
            ended_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv && is_text) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            tpos_reg  <= tpos_next;
            ended_reg <= ended_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (adv && is_text) begin
            m_item_reg <= m_item_next;
        end
        if (win_take) begin
            for (int i = 0; i < aws_pkg::WORD_MAX; i++) begin
                win_ch_reg[i]  <= win_ch_next[i];
                win_pos_reg[i] <= win_pos_next[i];
            end
        end
    end

endmodule
